@@ rtl/mte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

    // Element and coordinate width, signed fixed point
    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Input opcodes
    localparam logic [1:0] OP_WR_CUR = 2'd0;
    localparam logic [1:0] OP_WR_OPD = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;
    localparam logic [1:0] OP_IDENT  = 2'd3;

    // Result kinds
    localparam logic KIND_ELEM  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic load;   // seed the accumulator, drop any product in flight
        logic issue;  // multiply the operands presented this cycle
    } t_mac_ctrl;

endpackage

`default_nettype wire

@@ rtl/mte_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mte_mac #(
    parameter int FRAC_BITS = mte_pkg::FRAC_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire mte_pkg::t_mac_ctrl          i_ctrl,
    input  wire logic signed [mte_pkg::ELEM_W-1:0] i_seed,
    input  wire logic signed [mte_pkg::ELEM_W-1:0] i_a,
    input  wire logic signed [mte_pkg::ELEM_W-1:0] i_b,
    output logic                             o_pv,
    output logic        [mte_pkg::ELEM_W-1:0] o_sum_sat
);

    localparam int EW    = mte_pkg::ELEM_W;
    localparam int PW    = 2 * EW;
    localparam int SH_W  = PW - FRAC_BITS;
    localparam int ACC_W = SH_W + 3;

    logic signed [PW-1:0]    r_prod;
    logic                    r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic        [SH_W-1:0]  w_sh;
    logic        [ACC_W-1:0] w_sum;
    logic                    w_fits;

    // Floor shift of the registered product, then the running sum with it
    assign w_sh  = r_prod[PW-1:FRAC_BITS];
    assign w_sum = r_pv ? (r_acc + {{3{w_sh[SH_W-1]}}, w_sh}) : r_acc;

    // Saturate: the sum fits when all bits above the sign of a word agree
    assign w_fits = (&w_sum[ACC_W-1:EW-1]) | ~(|w_sum[ACC_W-1:EW-1]);

    always_comb begin
        if (w_fits) begin
            o_sum_sat = w_sum[EW-1:0];
        end else if (w_sum[ACC_W-1]) begin
            o_sum_sat = {1'b1, {(EW-1){1'b0}}};
        end else begin
            o_sum_sat = {1'b0, {(EW-1){1'b1}}};
        end
    end

    assign o_pv = r_pv;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= i_a * i_b;
        end
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_ctrl.load) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= {{(ACC_W-EW){i_seed[EW-1]}}, i_seed};
        end else if (r_pv) begin
            r_acc <= w_sum;
        end
    end

endmodule

`default_nettype wire

@@ rtl/matrix4_transform_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 4x4 matrix engine in signed fixed point with FRAC_BITS fraction bits. One
// shared 32x32 multiplier followed by an accumulator does all arithmetic,
// one product term per cycle. A point transform runs three coordinates, each
// three terms plus a drain and saturate step, and then hands the word to the
// output register; a new point is accepted only after that hand-off. The
// final operand write starts a matrix product: 16 elements, each four terms,
// a drain and a hand-off, and a hand-off waits while the output is stalled.
// Input stall is high for the whole operation; the output register lets the
// next word be accepted while a result waits.
module matrix4_transform_engine #(
    parameter int FRAC_BITS = mte_pkg::FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_opcode,
    input  wire  [1:0]  i_row_index,
    input  wire  [1:0]  i_col_index,
    input  wire  signed [31:0] i_element_value,
    input  wire         i_operand_done,
    input  wire  signed [31:0] i_point_x,
    input  wire  signed [31:0] i_point_y,
    input  wire  signed [31:0] i_point_z,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_result_kind,
    output logic [1:0]  o_out_row,
    output logic [1:0]  o_out_col,
    output logic signed [31:0] o_out_element,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic        o_last_of_run
);

    localparam int EW = mte_pkg::ELEM_W;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic                 r_mat;
    logic [1:0]           r_i;
    logic [1:0]           r_j;
    logic [1:0]           r_k;
    logic                 r_issue_done;
    logic signed [EW-1:0] r_cur [16];
    logic signed [EW-1:0] r_opd [16];
    logic signed [EW-1:0] r_pin [3];
    logic signed [EW-1:0] r_pout [3];
    logic signed [EW-1:0] r_rowbuf [3];
    logic signed [EW-1:0] r_res;

    logic                 r_ovalid;
    logic                 r_okind;
    logic [1:0]           r_orow;
    logic [1:0]           r_ocol;
    logic signed [EW-1:0] r_oelem;
    logic signed [EW-1:0] r_ox;
    logic signed [EW-1:0] r_oy;
    logic signed [EW-1:0] r_oz;
    logic                 r_olast;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_start_mat;
    logic                 w_start_pt;
    logic [1:0]           w_last_k;
    logic                 w_fin;
    logic                 w_next_dot;
    mte_pkg::t_mac_ctrl   w_ctrl;
    logic signed [EW-1:0] w_seed;
    logic signed [EW-1:0] w_a;
    logic signed [EW-1:0] w_b;
    logic                 w_pv;
    logic [EW-1:0]        w_sum;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_ovalid || !i_out_stall;
    assign w_start_mat = w_in_acc && (i_opcode == mte_pkg::OP_WR_OPD) && i_operand_done;
    assign w_start_pt  = w_in_acc && (i_opcode == mte_pkg::OP_POINT);
    assign w_last_k    = r_mat ? 2'd3 : 2'd2;
    assign w_fin       = (r_state == S_RUN) && r_issue_done && w_pv;
    // Next dot product: another coordinate, or another element after hand-off
    assign w_next_dot  = (w_fin && !r_mat && (r_j != 2'd2))
                      || ((r_state == S_OUT) && w_out_free && r_mat
                          && !((r_i == 2'd3) && (r_j == 2'd3)));

    // Operand selection for the shared multiplier
    always_comb begin
        if (r_mat) begin
            w_a = r_cur[{r_i, r_k}];
            w_b = r_opd[{r_k, r_j}];
        end else begin
            w_a = (r_k == 2'd0) ? r_pin[0] : ((r_k == 2'd1) ? r_pin[1] : r_pin[2]);
            w_b = r_cur[{r_k, r_j}];
        end
    end

    // Seed: translation row for points, zero for product elements
    always_comb begin
        if (w_start_pt) begin
            w_seed = r_cur[{2'd3, 2'd0}];
        end else if (!r_mat && (r_state == S_RUN)) begin
            w_seed = r_cur[{2'd3, r_j + 2'd1}];
        end else begin
            w_seed = '0;
        end
    end

    assign w_ctrl.load  = w_start_mat || w_start_pt || w_next_dot;
    assign w_ctrl.issue = (r_state == S_RUN) && !r_issue_done;

    mte_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_seed    (w_seed),
        .i_a       (w_a),
        .i_b       (w_b),
        .o_pv      (w_pv),
        .o_sum_sat (w_sum)
    );

    // Sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start_mat || w_start_pt) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_fin && (r_mat || (r_j == 2'd2))) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = w_next_dot ? S_RUN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Term counters and element position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat        <= 1'b0;
            r_i          <= 2'd0;
            r_j          <= 2'd0;
            r_k          <= 2'd0;
            r_issue_done <= 1'b0;
        end else if (w_start_mat || w_start_pt) begin
            r_mat        <= w_start_mat;
            r_i          <= 2'd0;
            r_j          <= 2'd0;
            r_k          <= 2'd0;
            r_issue_done <= 1'b0;
        end else if (w_next_dot) begin
            r_k          <= 2'd0;
            r_issue_done <= 1'b0;
            if (r_mat && (r_j == 2'd3)) begin
                r_i <= r_i + 2'd1;
            end
            r_j <= r_j + 2'd1;
        end else if (w_ctrl.issue) begin
            r_k <= r_k + 2'd1;
            if (r_k == w_last_k) begin
                r_issue_done <= 1'b1;
            end
        end
    end

    // Latch the point and the finished sums
    always_ff @(posedge i_clk) begin
        if (w_start_pt) begin
            r_pin[0] <= i_point_x;
            r_pin[1] <= i_point_y;
            r_pin[2] <= i_point_z;
        end
        if (w_fin) begin
            r_res <= w_sum;
            if (!r_mat && (r_j != 2'd3)) begin
                r_pout[r_j] <= w_sum;
            end
        end
    end

    // Hold finished elements of the row until the whole row is done
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free && r_mat && (r_j != 2'd3)) begin
            r_rowbuf[r_j] <= r_res;
        end
    end

    // Current and operand matrices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 16; n++) begin
                r_cur[n] <= (n % 5 == 0) ? ONE : '0;
                r_opd[n] <= '0;
            end
        end else begin
            if (w_in_acc && (i_opcode == mte_pkg::OP_WR_CUR)) begin
                r_cur[{i_row_index, i_col_index}] <= i_element_value;
            end
            if (w_in_acc && (i_opcode == mte_pkg::OP_IDENT)) begin
                for (int n = 0; n < 16; n++) begin
                    r_cur[n] <= (n % 5 == 0) ? ONE : '0;
                end
            end
            if (w_in_acc && (i_opcode == mte_pkg::OP_WR_OPD)) begin
                r_opd[{i_row_index, i_col_index}] <= i_element_value;
            end
            // Write back a finished product row
            if ((r_state == S_OUT) && w_out_free && r_mat && (r_j == 2'd3)) begin
                r_cur[{r_i, 2'd0}] <= r_rowbuf[0];
                r_cur[{r_i, 2'd1}] <= r_rowbuf[1];
                r_cur[{r_i, 2'd2}] <= r_rowbuf[2];
                r_cur[{r_i, 2'd3}] <= r_res;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            if (r_mat) begin
                r_okind <= mte_pkg::KIND_ELEM;
                r_orow  <= r_i;
                r_ocol  <= r_j;
                r_oelem <= r_res;
                r_ox    <= '0;
                r_oy    <= '0;
                r_oz    <= '0;
                r_olast <= (r_i == 2'd3) && (r_j == 2'd3);
            end else begin
                r_okind <= mte_pkg::KIND_POINT;
                r_orow  <= 2'd0;
                r_ocol  <= 2'd0;
                r_oelem <= '0;
                r_ox    <= r_pout[0];
                r_oy    <= r_pout[1];
                r_oz    <= r_res;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_out_row     = r_orow;
    assign o_out_col     = r_ocol;
    assign o_out_element = r_oelem;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_last_of_run = r_olast;

    // A word that starts a computation must close the input
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_start_mat || w_start_pt) |=> o_in_stall)
        else $error("input not stalled after starting a computation");

    // A point result is always the last of its run
    a_point_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == mte_pkg::KIND_POINT)) |-> o_last_of_run)
        else $error("point result without last flag");

    // Only the bottom-right product element closes a product run
    a_elem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == mte_pkg::KIND_ELEM))
        |-> (o_last_of_run == ((o_out_row == 2'd3) && (o_out_col == 2'd3))))
        else $error("last flag on wrong product element");

    // The finish of a dot product only happens with a term issued just before it
    a_fin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |-> $past(w_ctrl.issue))
        else $error("dot product finished without a preceding term");

endmodule

`default_nettype wire

@@ dv/matrix4_transform_checker.sv @@
`timescale 1ns / 1ps

module matrix4_transform_checker #(
    parameter int FRAC_BITS = mte_pkg::FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [1:0]  i_opcode,
    input  wire  [1:0]  i_row_index,
    input  wire  [1:0]  i_col_index,
    input  wire  signed [31:0] i_element_value,
    input  wire         i_operand_done,
    input  wire  signed [31:0] i_point_x,
    input  wire  signed [31:0] i_point_y,
    input  wire  signed [31:0] i_point_z,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire         i_result_kind,
    input  wire  [1:0]  i_out_row,
    input  wire  [1:0]  i_out_col,
    input  wire  signed [31:0] i_out_element,
    input  wire  signed [31:0] i_out_x,
    input  wire  signed [31:0] i_out_y,
    input  wire  signed [31:0] i_out_z,
    input  wire         i_last_of_run,
    output int          o_fail_count,
    output int          o_pending
);

    import mte_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic              kind;
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [31:0] elem;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic              last;
    } t_result_word;

    // Shadow copies of the engine's two matrices, row-major
    logic signed [31:0] active_mtx [16];
    logic signed [31:0] staged_mtx [16];
    t_result_word       due_words [$];

    // Full product, then floor division by the fraction scale
    function automatic longint fixed_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint full;
        full = longint'(a) * longint'(b);
        return full >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clamp32(longint s);
        if (s > SAT_HI) return 32'sh7fff_ffff;
        if (s < SAT_LO) return 32'sh8000_0000;
        return 32'(s);
    endfunction

    task automatic load_identity();
        for (int i = 0; i < 16; i++)
            active_mtx[i] = (i % 5 == 0) ? (32'sd1 << FRAC_BITS) : 32'sd0;
    endtask

    // Replace active by active x staged and queue all 16 elements
    task automatic multiply_into_active();
        longint             acc;
        logic signed [31:0] prod [16];
        t_result_word       w;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += fixed_mul(active_mtx[r * 4 + k], staged_mtx[k * 4 + c]);
                prod[r * 4 + c] = clamp32(acc);
            end
        end
        for (int i = 0; i < 16; i++) begin
            active_mtx[i] = prod[i];
            w.kind = KIND_ELEM;
            w.row  = 2'(i >> 2);
            w.col  = 2'(i & 3);
            w.elem = prod[i];
            w.x    = '0;
            w.y    = '0;
            w.z    = '0;
            w.last = (i == 15);
            due_words.push_back(w);
        end
    endtask

    // Row vector (x, y, z, 1) times the active matrix
    task automatic transform_point();
        longint       acc;
        t_result_word w;
        logic signed [31:0] coord [3];
        for (int c = 0; c < 3; c++) begin
            acc = fixed_mul(i_point_x, active_mtx[c]) + fixed_mul(i_point_y, active_mtx[4 + c])
                + fixed_mul(i_point_z, active_mtx[8 + c]) + longint'(active_mtx[12 + c]);
            coord[c] = clamp32(acc);
        end
        w.kind = KIND_POINT;
        w.row  = '0;
        w.col  = '0;
        w.elem = '0;
        w.x    = coord[0];
        w.y    = coord[1];
        w.z    = coord[2];
        w.last = 1'b1;
        due_words.push_back(w);
    endtask

    task automatic apply_command();
        int idx;
        idx = {i_row_index, i_col_index};
        case (i_opcode)
            OP_WR_CUR: active_mtx[idx] = i_element_value;
            OP_IDENT:  load_identity();
            OP_WR_OPD: begin
                staged_mtx[idx] = i_element_value;
                if (i_operand_done)
                    multiply_into_active();
            end
            OP_POINT:  transform_point();
            default: ;
        endcase
    endtask

    // Compare one delivered word with the oldest one due
    task automatic compare_word();
        t_result_word w;
        if (due_words.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected word kind=%0d row=%0d col=%0d elem=%0d",
                         $realtime, i_result_kind, i_out_row, i_out_col, i_out_element);
            return;
        end
        w = due_words.pop_front();
        if (w.kind !== i_result_kind || w.row !== i_out_row || w.col !== i_out_col ||
            w.elem !== i_out_element || w.x !== i_out_x || w.y !== i_out_y ||
            w.z !== i_out_z || w.last !== i_last_of_run) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $write("%0t: mismatch expected kind=%0d row=%0d col=%0d elem=%0d ",
                       $realtime, w.kind, w.row, w.col, w.elem);
                $write("x=%0d y=%0d z=%0d last=%0d, got kind=%0d row=%0d col=%0d ",
                       w.x, w.y, w.z, w.last, i_result_kind, i_out_row, i_out_col);
                $display("elem=%0d x=%0d y=%0d z=%0d last=%0d",
                         i_out_element, i_out_x, i_out_y, i_out_z, i_last_of_run);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Check delivered words first: nothing accepted on this edge can show up yet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_identity();
            for (int i = 0; i < 16; i++)
                staged_mtx[i] = '0;
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                compare_word();
            if (i_in_valid && !i_in_stall)
                apply_command();
        end
        o_pending = due_words.size();
    end

endmodule

@@ dv/matrix4_transform_engine_test.sv @@
`timescale 1ns / 1ps

module matrix4_transform_engine_test;

    import mte_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 500;

    localparam logic signed [31:0] MAX_FIX = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_FIX = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_FIX = 32'sd1 << FRAC;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic signed [31:0] element_value;
    logic        operand_done;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic signed [31:0] out_element;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        last_of_run;

    int  fail_count;
    int  pending_words;
    bit  long_hold_pending;
    bit  send_calm;
    int  n_words;
    int  n_points;
    int  n_products;
    int  n_writes;
    int  n_identity;

    matrix4_transform_engine #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_row_index     (row_index),
        .i_col_index     (col_index),
        .i_element_value (element_value),
        .i_operand_done  (operand_done),
        .i_point_x       (point_x),
        .i_point_y       (point_y),
        .i_point_z       (point_z),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (result_kind),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_out_element   (out_element),
        .o_out_x         (out_x),
        .o_out_y         (out_y),
        .o_out_z         (out_z),
        .o_last_of_run   (last_of_run)
    );

    matrix4_transform_checker #(
        .FRAC_BITS(FRAC)
    ) check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_opcode        (opcode),
        .i_row_index     (row_index),
        .i_col_index     (col_index),
        .i_element_value (element_value),
        .i_operand_done  (operand_done),
        .i_point_x       (point_x),
        .i_point_y       (point_y),
        .i_point_z       (point_z),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_kind   (result_kind),
        .i_out_row       (out_row),
        .i_out_col       (out_col),
        .i_out_element   (out_element),
        .i_out_x         (out_x),
        .i_out_y         (out_y),
        .i_out_z         (out_z),
        .i_last_of_run   (last_of_run),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Draw a random wait; flip into and out of stretches with no waits
    function automatic int pause_cycles(inout bit calm);
        if ($urandom_range(0, 23) == 0)
            calm = ~calm;
        return calm ? 0 : int'($urandom_range(0, 3));
    endfunction

    // Mix of extremes, full-range words and small fixed-point values
    function automatic logic signed [31:0] fixed_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return MAX_FIX;
                    1:       return MIN_FIX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2:    return $urandom;
            default: return $signed($urandom_range(0, 8 << FRAC)) - (32'sd4 << FRAC);
        endcase
    endfunction

    // Offer one word after a random gap; called and returns just after a falling edge
    task automatic send_word(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                             logic signed [31:0] value, logic done,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        int gap;
        gap = pause_cycles(send_calm);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode        = op;
        row_index     = row;
        col_index     = col;
        element_value = value;
        operand_done  = done;
        point_x       = px;
        point_y       = py;
        point_z       = pz;
        in_valid      = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        n_words++;
    endtask

    task automatic issue_point(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
        send_word(OP_POINT, 2'($urandom), 2'($urandom), $urandom, 1'($urandom), px, py, pz);
        n_points++;
    endtask

    task automatic issue_write(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                               logic signed [31:0] value, logic done);
        send_word(op, row, col, value, done, $urandom, $urandom, $urandom);
        if (op == OP_WR_OPD && done)
            n_products++;
        else
            n_writes++;
    endtask

    task automatic issue_identity();
        send_word(OP_IDENT, 2'($urandom), 2'($urandom), $urandom, 1'($urandom),
                  $urandom, $urandom, $urandom);
        n_identity++;
    endtask

    // Output side: random stalls per word, plus one long hold-off on request
    initial begin : output_side
        int  n;
        bit  calm;
        out_stall = 1'b0;
        calm      = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            n = pause_cycles(calm);
            if (n > 0) begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Stimulus
    initial begin : input_side
        int start;
        int pick;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        opcode            = OP_WR_CUR;
        row_index         = '0;
        col_index         = '0;
        element_value     = '0;
        operand_done      = 1'b0;
        point_x           = '0;
        point_y           = '0;
        point_z           = '0;
        long_hold_pending = 1'b0;
        send_calm         = 1'b0;
        n_words           = 0;
        n_points          = 0;
        n_products        = 0;
        n_writes          = 0;
        n_identity        = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Points through the reset identity
        issue_point(MIN_FIX, MAX_FIX, -32'sd1);
        issue_point(32'sd1, -ONE_FIX, MAX_FIX);
        // Extreme elements so that sums saturate both ways, z through column 2
        issue_write(OP_WR_CUR, 2'd0, 2'd0, MAX_FIX, 1'b1);
        issue_write(OP_WR_CUR, 2'd1, 2'd0, MAX_FIX, 1'b0);
        issue_write(OP_WR_CUR, 2'd3, 2'd0, MAX_FIX, 1'b1);
        issue_write(OP_WR_CUR, 2'd2, 2'd2, MIN_FIX, 1'b0);
        issue_write(OP_WR_CUR, 2'd3, 2'd2, MIN_FIX, 1'b1);
        issue_point(MAX_FIX, MAX_FIX, MAX_FIX);
        issue_point(MIN_FIX, MIN_FIX, MIN_FIX);
        // Product against a single-element operand
        issue_write(OP_WR_OPD, 2'd3, 2'd3, MIN_FIX, 1'b1);
        issue_identity();
        // Short operand load, multiply on the last write
        issue_write(OP_WR_OPD, 2'd0, 2'd0, MAX_FIX, 1'b0);
        issue_write(OP_WR_OPD, 2'd1, 2'd1, MIN_FIX, 1'b0);
        issue_write(OP_WR_OPD, 2'd2, 2'd2, 3 * ONE_FIX, 1'b0);
        issue_write(OP_WR_OPD, 2'd3, 2'd2, -32'sd1, 1'b1);
        issue_point(fixed_sample(), fixed_sample(), fixed_sample());
        issue_write(OP_WR_CUR, 2'd1, 2'd3, -(ONE_FIX >>> 1), 1'b0);
        issue_point(ONE_FIX, 2 * ONE_FIX, -3 * ONE_FIX);
        issue_identity();
        issue_point(ONE_FIX, ONE_FIX, ONE_FIX);

        // Hold the output off while points keep coming so the engine backs up
        long_hold_pending = 1'b1;
        repeat (8)
            issue_point(fixed_sample(), fixed_sample(), fixed_sample());

        // Random mix; whole operand loads dominate the multiply traffic
        start = n_words;
        while (n_words - start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                issue_point(fixed_sample(), fixed_sample(), fixed_sample());
            end else if (pick < 63) begin
                issue_write(OP_WR_CUR, 2'($urandom), 2'($urandom), fixed_sample(),
                            1'($urandom));
            end else if (pick < 75) begin
                pick = $urandom_range(0, 15);
                for (int k = 0; k < 16; k++)
                    issue_write(OP_WR_OPD, 2'(((pick + k) % 16) >> 2), 2'((pick + k) % 4),
                                fixed_sample(), k == 15);
            end else if (pick < 88) begin
                issue_write(OP_WR_OPD, 2'($urandom), 2'($urandom), fixed_sample(),
                            $urandom_range(0, 3) == 0);
            end else begin
                issue_identity();
            end
        end
        in_valid = 1'b0;

        // Drain, then give the engine time to show any stray word
        while (pending_words != 0) @(negedge clk);
        repeat (150) @(negedge clk);

        $display("covered %0d words: %0d point transforms, %0d matrix products, %0d writes,",
                 n_words, n_points, n_products, n_writes);
        $display("%0d identity loads, one %0d-cycle output hold-off, random gaps on both sides",
                 n_identity, HOLD_CYCLES);
        if (fail_count == 0 && pending_words == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run
    initial begin : watchdog
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
